// ----- rtl/core/sld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the sync/length/checksum deframer
// Holds the parse phases, status codes, the command that travels from the
// parser to the result sequencer, and the default payload store size.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int IDX_W           = 6;
	localparam int ERR_W           = 32;
	localparam int CFG_IDX_W       = 8;
	localparam int FIFO_DEPTH      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CSUM  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_LONG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_READ = 2'd1,
		B_LOAD = 2'd2,
		B_OUT  = 2'd3
	} back_state_t;

	// One finished frame or one error, as handed from parser to sequencer.
	typedef struct packed {
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] frame_length;
		status_t           status;
		logic              has_payload;
		logic              bank;
		logic [ERR_W-1:0]  error_total;
	} cmd_t;

	// Payload bank handed back by the sequencer once fully drained.
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

endpackage

// ----- rtl/core/sld_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_in_if: received byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface sld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sld_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_out_if: frame result channel
// Valid/ready channel carrying one payload byte or status per transaction.
// ----------------------------------------------------------------------------
interface sld_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_id;
	logic [7:0]  frame_length;
	logic [5:0]  byte_index;
	logic [7:0]  payload_byte;
	logic        has_payload;
	logic        last;
	logic [1:0]  status;
	logic [31:0] error_total;

	modport source (output valid, output frame_id, output frame_length,
		output byte_index, output payload_byte, output has_payload, output last,
		output status, output error_total, input ready);
	modport sink (input valid, input frame_id, input frame_length,
		input byte_index, input payload_byte, input has_payload, input last,
		input status, input error_total, output ready);
endinterface

// ----- rtl/core/sld_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sld_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sld_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sld_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- rtl/core/sld_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_front: byte parser
// Hunts for the sync pair, takes id and length, writes payload into one of
// two RAM banks, checks the sum and posts a command per frame or error.
// ----------------------------------------------------------------------------
module sld_front #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	sld_in_if.sink                              rx,
	input  logic [7:0]                          sync_first,
	input  logic [7:0]                          sync_second,
	output logic                                cmd_push,
	output sld_pkg::cmd_t                       cmd_data,
	input  logic                                cmd_full,
	input  sld_pkg::bank_rel_t                  rel,
	output logic                                ram_we,
	output logic [$clog2(2*MAX_PAYLOAD)-1:0]    ram_waddr,
	output logic [7:0]                          ram_wdata
);
	import sld_pkg::*;

	localparam int FW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = $clog2(2 * MAX_PAYLOAD);

	phase_t           phase_q, phase_d;
	logic [7:0]       id_q;
	logic [7:0]       len_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    fill_inc;
	logic [7:0]       sum_q;
	logic [7:0]       sum_add;
	logic [ERR_W-1:0] err_q;
	logic [1:0]       busy_q, busy_d;
	logic             wr_bank_q;
	logic             fire;
	logic             too_long;
	logic             sum_ok;
	logic             frame_push;

	assign fire     = rx.valid && rx.ready;
	assign fill_inc = fill_q + FW'(1);
	assign sum_add  = sum_q + rx.rx_byte;
	assign too_long = rx.rx_byte > 8'(MAX_PAYLOAD);
	assign sum_ok   = sum_q == rx.rx_byte;

	assign ram_we    = fire && (phase_q == PH_DATA);
	assign ram_waddr = AW'(fill_q) + (wr_bank_q ? AW'(MAX_PAYLOAD) : AW'(0));
	assign ram_wdata = rx.rx_byte;

	// Next phase, ready and command generation.
	always_comb begin
		phase_d    = phase_q;
		rx.ready   = 1'b1;
		cmd_push   = 1'b0;
		frame_push = 1'b0;
		cmd_data   = '{frame_id: id_q, frame_length: len_q, status: ST_OK,
			has_payload: 1'b0, bank: wr_bank_q, error_total: err_q};
		case (phase_q)
			PH_SYNC2: begin
				if (rx.rx_byte == sync_second) begin
					phase_d = PH_ID;
				end else if (rx.rx_byte != sync_first) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_ID: begin
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				rx.ready = !cmd_full;
				cmd_data.frame_length = rx.rx_byte;
				if (rx.rx_byte == 8'd0) begin
					phase_d = PH_CSUM;
				end else if (too_long) begin
					phase_d              = PH_SYNC1;
					cmd_push             = fire;
					cmd_data.status      = ST_LONG;
					cmd_data.error_total = err_q + ERR_W'(1);
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				rx.ready = !busy_q[wr_bank_q];
				if (8'(fill_inc) >= len_q) begin
					phase_d = PH_CSUM;
				end
			end
			PH_CSUM: begin
				rx.ready = !cmd_full;
				phase_d  = PH_SYNC1;
				cmd_push = fire;
				if (sum_ok) begin
					cmd_data.has_payload = len_q != 8'd0;
					frame_push           = fire && (len_q != 8'd0);
				end else begin
					cmd_data.status      = ST_BAD;
					cmd_data.error_total = err_q + ERR_W'(1);
				end
			end
			default: begin
				phase_d = (rx.rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (frame_push) begin
			busy_d[wr_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			id_q      <= '0;
			len_q     <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			err_q     <= '0;
			busy_q    <= '0;
			wr_bank_q <= 1'b0;
		end else begin
			busy_q <= busy_d;
			if (fire) begin
				phase_q <= phase_d;
				case (phase_q)
					PH_ID: begin
						id_q  <= rx.rx_byte;
						sum_q <= rx.rx_byte;
					end
					PH_LEN: begin
						len_q  <= rx.rx_byte;
						fill_q <= '0;
						sum_q  <= sum_add;
						if (rx.rx_byte != 8'd0 && too_long) begin
							err_q <= err_q + ERR_W'(1);
						end
					end
					PH_DATA: begin
						fill_q <= fill_inc;
						sum_q  <= sum_add;
					end
					PH_CSUM: begin
						if (!sum_ok) begin
							err_q <= err_q + ERR_W'(1);
						end
						if (frame_push) begin
							wr_bank_q <= !wr_bank_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule

// ----- rtl/core/sld_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_cmd_fifo: command queue between parser and result sequencer
// Small register FIFO of frame commands.
// ----------------------------------------------------------------------------
module sld_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sld_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output sld_pkg::cmd_t pop_data,
	output logic          not_empty
);
	import sld_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_t          entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

// ----- rtl/core/sld_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_back: result sequencer
// Takes commands from the queue and plays out one result per payload byte,
// reading the bank from RAM, or one status result for errors and empty frames.
// ----------------------------------------------------------------------------
module sld_back #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  sld_pkg::cmd_t                    cmd_data,
	output logic                             cmd_pop,
	output logic                             ram_re,
	output logic [$clog2(2*MAX_PAYLOAD)-1:0] ram_raddr,
	input  logic [7:0]                       ram_rdata,
	output sld_pkg::bank_rel_t               rel,
	sld_out_if.source                        res
);
	import sld_pkg::*;

	localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int AW = $clog2(2 * MAX_PAYLOAD);

	back_state_t       state_q, state_d;
	cmd_t              cmd_q;
	logic [IW-1:0]     idx_q;
	logic [IDX_W-1:0]  byte_index_q;
	logic [BYTE_W-1:0] payload_q;
	logic              has_q;
	logic              last_q;
	logic              idx_last;

	assign idx_last  = (8'(idx_q) + 8'd1) == cmd_q.frame_length;
	assign ram_raddr = AW'(idx_q) + (cmd_q.bank ? AW'(MAX_PAYLOAD) : AW'(0));

	assign res.valid        = state_q == B_OUT;
	assign res.frame_id     = cmd_q.frame_id;
	assign res.frame_length = cmd_q.frame_length;
	assign res.status       = cmd_q.status;
	assign res.error_total  = cmd_q.error_total;
	assign res.byte_index   = byte_index_q;
	assign res.payload_byte = payload_q;
	assign res.has_payload  = has_q;
	assign res.last         = last_q;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		ram_re    = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = cmd_q.bank;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = cmd_data.has_payload ? B_READ : B_OUT;
				end
			end
			B_READ: begin
				ram_re  = 1'b1;
				state_d = B_LOAD;
			end
			B_LOAD: begin
				state_d = B_OUT;
			end
			B_OUT: begin
				if (res.ready) begin
					if (cmd_q.has_payload && !last_q) begin
						state_d = B_READ;
					end else begin
						rel.valid = cmd_q.has_payload;
						state_d   = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_q        <= cmd_data;
					idx_q        <= '0;
					byte_index_q <= '0;
					payload_q    <= '0;
					has_q        <= 1'b0;
					last_q       <= 1'b1;
				end
			end
			B_LOAD: begin
				byte_index_q <= IDX_W'(idx_q);
				payload_q    <= ram_rdata;
				has_q        <= 1'b1;
				last_q       <= idx_last;
			end
			B_OUT: begin
				if (res.ready && cmd_q.has_payload && !last_q) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- rtl/core/sync_length_checksum_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer: two-byte sync, length and checksum deframer
// Parses a received byte stream into frames and emits payload byte results.
// ----------------------------------------------------------------------------
// With the sequencer idle, a status-only result passes the command queue
// and sequencer state after its checksum or too-long length byte. The
// parser takes one byte per cycle unless the queue is full or the bank is
// busy; a payload result takes read, load, output states, plus idle per frame.
// Reset: arst_n clears parser phase, sums, error count, queue and sequencer;
// the payload RAM is not cleared and needs no clearing pass.
module sync_length_checksum_deframer #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sld_cfg_if.sink    cfg,
	sld_in_if.sink     rx,
	sld_out_if.source  res
);
	import sld_pkg::*;

	localparam int AW = $clog2(2 * MAX_PAYLOAD);

	// Sync byte registers. Writes to indexes beyond the list are dropped, and
	// the port never stalls.
	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;

	// Parser to queue.
	logic       cmd_push;
	cmd_t       cmd_push_data;
	logic       cmd_full;

	// Queue to sequencer.
	logic       cmd_pop;
	cmd_t       cmd_pop_data;
	logic       cmd_not_empty;

	// The sequencer returns a payload bank to the parser once drained.
	bank_rel_t  rel;

	// Payload RAM: two banks of MAX_PAYLOAD bytes, so the parser fills one
	// frame while the sequencer plays out the previous one.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_SYNC_FIRST) begin
				sync_first_q <= cfg.data;
			end else if (cfg.index == CFG_SYNC_SECOND) begin
				sync_second_q <= cfg.data;
			end
		end
	end

	// Front: accepts one byte per transaction, tracks the frame phase and the
	// running sum, and posts one command for each finished frame or error.
	sld_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_push_data),
		.cmd_full    (cmd_full),
		.rel         (rel),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	// Short queue that decouples parsing from result play-out.
	sld_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_push_data),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_pop_data),
		.not_empty (cmd_not_empty)
	);

	sld_ram #(
		.WIDTH (8),
		.DEPTH (2 * MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Back: turns each command into its results on the output channel, which
	// is driven straight from registers.
	sld_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_not_empty),
		.cmd_data  (cmd_pop_data),
		.cmd_pop   (cmd_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rel       (rel),
		.res       (res)
	);

`ifndef SYNTHESIS
	// Payload results only ever come from frames whose checksum matched.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.has_payload |-> res.status == ST_OK)
	else $error("payload result with error status");

	// Status-only results are single, zero-filled and closing.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.has_payload |->
			res.last && res.byte_index == '0 && res.payload_byte == '0)
	else $error("malformed status-only result");

	// The last payload result sits at the final position of the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.has_payload && res.last |->
			res.byte_index == IDX_W'(res.frame_length - 8'd1))
	else $error("last payload result at wrong index");

	// The queue never takes a command while full.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_full |-> !cmd_push)
	else $error("command pushed into full queue");
`endif
endmodule
